// ===== hdl/lssd_pkg.sv =====
// lssd_pkg: shared types for the lifo stack with delete-by-value
// word layouts for both channels, operation codes and the cell control group
// no dependencies
package lssd_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [ValueW-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic              accepted;
    logic              found;
    logic [CountW-1:0] count;
  } out_word_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic              del;
    logic              hit;
    logic [ValueW-1:0] key;
  } cell_ctl_t;

endpackage

// ===== hdl/lssd_cell.sv =====
// lssd_cell: one slot of the stack row
// compares against the search key, passes the match flag down and takes the
// neighbour's word when a delete closes the gap; uses lssd_pkg
module lssd_cell (
  input  logic                            clk,
  input  lssd_pkg::cell_ctl_t             ctl,
  input  logic                            live,
  input  logic                            wr,
  input  logic [lssd_pkg::ValueW-1:0]     wr_data,
  input  logic [lssd_pkg::ValueW-1:0]     above_data,
  input  logic                            match_up,
  output logic                            match_dn,
  output logic [lssd_pkg::ValueW-1:0]     data
);

  logic own_match;
  logic shift;

  assign own_match = live && (data == ctl.key);
  assign match_dn  = match_up || own_match;
  // the highest match and everything above it move down one place
  assign shift     = ctl.del && ctl.hit && !match_up;

  always_ff @(posedge clk) begin
    if (wr) begin
      data <= wr_data;
    end else if (shift) begin
      data <= above_data;
    end
  end

endmodule

// ===== hdl/lifo_stack_search_delete.sv =====
// Bounded lifo of DEPTH signed 32-bit words built as a row of cells, one word
// per cell. Each input word is a push, a delete of the topmost equal entry or a
// clear, and gives one result word in the cycle after it is taken. One operation
// is taken per cycle while the output does not stall: every cell compares its
// word with the key at once and a match flag ripples from the top cell down
// the row, so that ripple through DEPTH cells sets the cycle time. The
// registered result frees the input side whenever the result is taken or the
// output slot is empty. The count field is the held count truncated to five bits.
// depends on lssd_pkg, lssd_cell
module lifo_stack_search_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lssd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lssd_pkg::out_word_t out_data
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]                   held;
  logic [CntW-1:0]                   held_next;
  logic                              take;
  logic                              full;
  logic [DEPTH:0]                    match_chain;
  logic [DEPTH-1:0]                  live;
  logic [DEPTH-1:0]                  wr;
  logic [lssd_pkg::ValueW-1:0]       cell_data [DEPTH];
  lssd_pkg::cell_ctl_t               ctl;
  logic                              res_acc;
  logic                              res_found;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign full     = (held == CntW'(DEPTH));

  assign ctl.del = take && (in_data.mode == lssd_pkg::MODE_DELETE);
  assign ctl.hit = match_chain[0];
  assign ctl.key = in_data.value;

  assign match_chain[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned AboveIdx = (i + 1 < DEPTH) ? i + 1 : i;

    assign live[i] = (CntW'(i) < held);
    assign wr[i]   = take && (in_data.mode == lssd_pkg::MODE_PUSH) && (held == CntW'(i));

    lssd_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .live       (live[i]),
      .wr         (wr[i]),
      .wr_data    (in_data.value),
      .above_data (cell_data[AboveIdx]),
      .match_up   (match_chain[i+1]),
      .match_dn   (match_chain[i]),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    held_next = held;
    res_acc   = 1'b0;
    res_found = 1'b0;
    unique case (in_data.mode)
      lssd_pkg::MODE_PUSH: begin
        if (!full) begin
          held_next = held + CntW'(1);
          res_acc   = 1'b1;
        end
      end
      lssd_pkg::MODE_DELETE: begin
        res_acc   = 1'b1;
        res_found = match_chain[0];
        if (match_chain[0]) begin
          held_next = held - CntW'(1);
        end
      end
      lssd_pkg::MODE_CLEAR: begin
        held_next = '0;
        res_acc   = 1'b1;
      end
      default: begin
        held_next = held;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.accepted <= res_acc;
      out_data.found    <= res_found;
      out_data.count    <= lssd_pkg::CountW'(held_next);
    end
  end

endmodule

// ===== hdl/lssd_checker.sv =====
// lssd_checker: port-level checks for the lifo stack, attached by bind
// depends on lssd_pkg and the top level lifo_stack_search_delete
module lssd_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input lssd_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lssd_pkg::out_word_t out_data
);

  // a held result word stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_found_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.found || out_data.accepted))
    else $error("found without accepted");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((DEPTH > 31) || (32'(out_data.count) <= DEPTH)))
    else $error("count above depth");

  // a clear always reports an empty store
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.mode == lssd_pkg::MODE_CLEAR)
    |=> out_valid && out_data.accepted && !out_data.found && (out_data.count == '0))
    else $error("clear result wrong");

  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word shown right after reset");

endmodule

bind lifo_stack_search_delete lssd_checker #(.DEPTH(DEPTH)) u_lssd_checker (.*);

// ===== tb/stack_result_checker.sv =====
// stack_result_checker: follows both channels of the lifo stack, keeps its own
// copy of the stack contents and compares every result word against it
// depends on lssd_pkg
`timescale 1ns / 100ps

module stack_result_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lssd_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lssd_pkg::out_word_t out_data,
  output int                  errors,
  output int                  pending
);

  logic signed [lssd_pkg::ValueW-1:0] stack_mem [DEPTH];
  int                                 held;
  lssd_pkg::out_word_t                expected_results [$];

  initial begin
    errors  = 0;
    pending = 0;
    held    = 0;
  end

  // applies one operation to the shadow stack and gives the result word it should cause
  function automatic lssd_pkg::out_word_t apply_stack_op(lssd_pkg::in_word_t w);
    lssd_pkg::out_word_t r;
    int                  pos;
    r   = '0;
    pos = -1;
    case (w.mode)
      lssd_pkg::MODE_PUSH: begin
        if (held < DEPTH) begin
          stack_mem[held] = w.value;
          held++;
          r.accepted = 1'b1;
        end
      end
      lssd_pkg::MODE_DELETE: begin
        r.accepted = 1'b1;
        // topmost equal entry wins
        for (int i = held - 1; i >= 0; i--)
          if (pos < 0 && stack_mem[i] == w.value) pos = i;
        if (pos >= 0) begin
          for (int k = pos; k < held - 1; k++) stack_mem[k] = stack_mem[k + 1];
          held--;
          r.found = 1'b1;
        end
      end
      lssd_pkg::MODE_CLEAR: begin
        held = 0;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.count = lssd_pkg::CountW'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    lssd_pkg::out_word_t want;
    if (rst) begin
      held = 0;
      expected_results.delete();
    end else begin
      // result side first so a stray word cannot pair with a same-edge prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no prediction waiting: %p", out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.accepted !== want.accepted) begin
            $error("accepted mismatch: expected %0b, got %0b", want.accepted,
                   out_data.accepted);
            errors++;
          end
          if (out_data.found !== want.found) begin
            $error("found mismatch: expected %0b, got %0b", want.found, out_data.found);
            errors++;
          end
          if (out_data.count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, out_data.count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_stack_op(in_data));
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// testbench: directed and random push / delete / clear words for the lifo stack
// with random idling on both channels; checking is done by stack_result_checker
// depends on lssd_pkg, lifo_stack_search_delete, stack_result_checker
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DEPTH       = 16;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int          RANDOM_OPS  = 400;
  localparam int          CALM_TAIL   = 60;
  localparam int          STALL_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lssd_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lssd_pkg::out_word_t out_data;
  int                  errors;
  int                  pending;

  bit                calm = 1'b0;
  int                ready_hold = 0;
  int                quiet_cycles = 0;
  logic signed [31:0] value_pool [8];

  always #5 clk = ~clk;

  lifo_stack_search_delete #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  stack_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      ready_hold = $urandom_range(1, 10) - 1;
      out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [1:0] m, input logic [31:0] v);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= lssd_pkg::in_word_t'({m, v});
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return value_pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    logic [31:0] fill_vals [16];
    int          push_pct;
    int          r;
    fill_vals = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF,
                  32'h1, 32'h55555555, 32'hAAAAAAAA, 32'h7,
                  32'h12345678, 32'h7, 32'h80000000, 32'hFFFFFFFE,
                  32'h40000000, 32'h7, 32'h0, 32'h7FFFFFFF};
    value_pool = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF,
                   $urandom, $urandom, $urandom, $urandom};
    push_pct = 50;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty store, the unused code and a clear with nothing held
    send_word(lssd_pkg::MODE_DELETE, 32'h5);
    send_word(MODE_UNUSED, 32'hFFFFFFFF);
    send_word(lssd_pkg::MODE_CLEAR, 32'h0);
    // fill to the brim with extremes and repeats, then one push too many
    foreach (fill_vals[i]) send_word(lssd_pkg::MODE_PUSH, fill_vals[i]);
    send_word(lssd_pkg::MODE_PUSH, 32'h3);
    send_word(lssd_pkg::MODE_DELETE, 32'h7);           // topmost of several copies, mid stack
    send_word(lssd_pkg::MODE_DELETE, 32'h7FFFFFFF);    // the top word itself
    send_word(lssd_pkg::MODE_DELETE, 32'h0BADCAFE);    // nothing equal
    send_word(lssd_pkg::MODE_CLEAR, 32'h0);
    send_word(lssd_pkg::MODE_DELETE, 32'h0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) begin
        push_pct = $urandom_range(35, 75);
        calm = ((n / 50) % 3 == 2);
      end
      if (n >= RANDOM_OPS - CALM_TAIL) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < push_pct) send_word(lssd_pkg::MODE_PUSH, pick_value());
      else if (r < 96) send_word(lssd_pkg::MODE_DELETE, pick_value());
      else if (r < 99) send_word(lssd_pkg::MODE_CLEAR, $urandom);
      else send_word(MODE_UNUSED, $urandom);
    end
    in_valid <= 1'b0;

    // let the checker log the last word before looking at its backlog
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lssd_pkg.sv
hdl/lssd_cell.sv
hdl/lifo_stack_search_delete.sv
hdl/lssd_checker.sv
tb/stack_result_checker.sv
tb/testbench.sv
